[rtl/core/mpbm_pkg.sv]
// shared types and codes for the byte mailbox
package mpbm_pkg;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_OPEN   = 3'd1,
    OP_CLOSE  = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_BLOCK = 2'd2;
  localparam logic [1:0] ST_SEAL  = 2'd3;

  localparam logic CFG_ID_BASE = 1'b0;
  localparam logic CFG_END_MARKER = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  // one decoded request
  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] pipe_id;
    logic [15:0] process_id;
    logic        open_mode;
    logic [7:0]  data_byte;
  } req_t;

  // one result
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] new_id;
    logic [7:0]  read_byte;
    logic        is_end;
    logic        wake_valid;
    logic [15:0] wake_pid;
  } rsp_t;

endpackage

[rtl/core/mpbm_store.sv]
// byte buffer memory, one write and one registered read port
module mpbm_store import mpbm_pkg::*; #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  // synchronous write and read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/multi_pipe_byte_mailbox.sv]
// top level of the multi pipe byte mailbox
// sequence: the head byte of the addressed pipe is read at the accepting edge, the
// request executes in the next cycle and its result is registered for the output step
// flow: a new request is accepted only in the idle step, after the last result is taken;
// the control sequence runs the idle, execute and output steps; a held result stalls input
// reset: synchronous; all slots free, owners invalid, table and configuration registers to defaults
module multi_pipe_byte_mailbox import mpbm_pkg::*; #(
  parameter int NUM_PIPES = 8,
  parameter int BUFFER_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // op[2:0], pipe_id[18:3], process_id[34:19], open_mode[35], data_byte[43:36]
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // status[1:0], new_id[17:2], read_byte[25:18], is_end[26], wake_valid[27],
  // wake_pid[43:28]
  output logic [47:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int DW = $clog2(BUFFER_DEPTH);
  localparam int FW = DW + 1;
  localparam int AW = SW + DW;
  localparam int CW = $clog2(NUM_PIPES + 1);

  state_t state, state_next;
  req_t   req;
  rsp_t   rsp;
  logic [7:0] id_base, end_marker;

  // per slot table
  logic [NUM_PIPES-1:0] used, wr_v, rd_v, blk, seal;
  logic [DW-1:0] head [NUM_PIPES];
  logic [FW-1:0] fill [NUM_PIPES];
  logic [15:0] wown [NUM_PIPES];
  logic [15:0] rown [NUM_PIPES];
  logic [SW-1:0] next_free;
  logic [CW-1:0] used_count;

  // decode slot
  logic [16:0] diff;
  logic idx_ok;
  logic [SW-1:0] s;
  assign diff = {1'b0, req.pipe_id} - {9'd0, id_base};
  assign idx_ok = !diff[16] && (diff[15:0] < 16'(NUM_PIPES));
  assign s = idx_ok ? diff[SW-1:0] : '0;

  // slot of the incoming request, used to fetch its head byte at acceptance
  logic [16:0] in_diff;
  logic [SW-1:0] in_s;
  assign in_diff = {1'b0, s_tdata[18:3]} - {9'd0, id_base};
  assign in_s = (!in_diff[16] && (in_diff[15:0] < 16'(NUM_PIPES))) ? in_diff[SW-1:0] : '0;

  // round robin free slot search
  logic [SW-1:0] free_k;
  always_comb begin
    logic [SW:0] kw;
    logic [SW-1:0] k;
    logic found;
    free_k = next_free;
    found = 1'b0;
    for (int n = 0; n < NUM_PIPES; n++) begin
      kw = (SW+1)'(next_free) + (SW+1)'(n);
      if (kw >= (SW+1)'(NUM_PIPES)) kw = kw - (SW+1)'(NUM_PIPES);
      k = kw[SW-1:0];
      if (!found && !used[k]) begin
        free_k = k;
        found = 1'b1;
      end
    end
  end

  // store addressing
  logic [DW:0] pos_sum;
  logic [DW-1:0] wpos;
  logic st_we;
  logic [7:0] st_rdata;
  assign pos_sum = {1'b0, head[s]} + fill[s][DW:0];
  assign wpos = (pos_sum >= (DW+1)'(BUFFER_DEPTH)) ?
                DW'(pos_sum - (DW+1)'(BUFFER_DEPTH)) : pos_sum[DW-1:0];

  mpbm_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr ({s, wpos}),
    .wdata (req.data_byte),
    .raddr ({in_s, head[in_s]}),
    .rdata (st_rdata)
  );

  // handshakes
  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {4'd0, rsp.wake_pid, rsp.wake_valid, rsp.is_end, rsp.read_byte,
                    rsp.new_id, rsp.status};

  // control sequence
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // write enable for a stored data byte
  logic wr_ok;
  assign wr_ok = idx_ok && used[s] && wr_v[s] && wown[s] == req.process_id;
  assign st_we = (state == S_EXEC) && req.op == OP_WRITE && wr_ok && !seal[s] &&
                 fill[s] < FW'(BUFFER_DEPTH) && req.data_byte != end_marker;

  // capture request
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      req.op <= s_tdata[2:0];
      req.pipe_id <= s_tdata[18:3];
      req.process_id <= s_tdata[34:19];
      req.open_mode <= s_tdata[35];
      req.data_byte <= s_tdata[43:36];
    end
  end

  // execute and update the table
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0; wr_v <= '0; rd_v <= '0; blk <= '0; seal <= '0;
      next_free <= '0; used_count <= '0;
      id_base <= 8'd3; end_marker <= 8'd255;
      for (int i = 0; i < NUM_PIPES; i++) begin
        head[i] <= '0; fill[i] <= '0; wown[i] <= '0; rown[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_ID_BASE) id_base <= cfg_data;
        else end_marker <= cfg_data;
      end
      if (state == S_EXEC) begin
        rsp <= '0;
        rsp.status <= ST_ERR;
        case (req.op)
          OP_CREATE: begin
            if (32'(used_count) < NUM_PIPES) begin
              used[free_k] <= 1'b1; head[free_k] <= '0; fill[free_k] <= '0;
              wr_v[free_k] <= 1'b0; rd_v[free_k] <= 1'b0;
              blk[free_k] <= 1'b0; seal[free_k] <= 1'b0;
              used_count <= used_count + 1'b1;
              rsp.new_id <= 16'(free_k) + {8'd0, id_base};
              next_free <= (free_k == SW'(NUM_PIPES - 1)) ? '0 : free_k + 1'b1;
              rsp.status <= ST_OK;
            end
          end
          OP_OPEN: begin
            if (idx_ok) begin
              logic fresh, ok, wv, rv, bk;
              fresh = !used[s];
              ok = !fresh || 32'(used_count) < NUM_PIPES;
              wv = fresh ? 1'b0 : wr_v[s];
              rv = fresh ? 1'b0 : rd_v[s];
              bk = fresh ? 1'b0 : blk[s];
              if (fresh && ok) begin
                used[s] <= 1'b1; head[s] <= '0; fill[s] <= '0;
                wr_v[s] <= 1'b0; rd_v[s] <= 1'b0; blk[s] <= 1'b0; seal[s] <= 1'b0;
                used_count <= used_count + 1'b1;
              end
              if (ok && req.open_mode) begin
                if (!wv || wown[s] == req.process_id) begin
                  wr_v[s] <= 1'b1; wown[s] <= req.process_id;
                  if (rv && bk) begin
                    rsp.wake_valid <= 1'b1; rsp.wake_pid <= rown[s]; blk[s] <= 1'b0;
                  end
                  rsp.status <= ST_OK;
                end
              end else if (ok) begin
                if (!rv || rown[s] == req.process_id) begin
                  rd_v[s] <= 1'b1; rown[s] <= req.process_id;
                  if (wv && bk) begin
                    rsp.wake_valid <= 1'b1; rsp.wake_pid <= wown[s]; blk[s] <= 1'b0;
                  end
                  rsp.status <= ST_OK;
                end
              end
            end
          end
          OP_CLOSE: begin
            if (idx_ok && used[s]) begin
              if (wr_v[s] && wown[s] == req.process_id) begin
                seal[s] <= 1'b1; wr_v[s] <= 1'b0;
                if (blk[s]) begin
                  if (rd_v[s]) begin
                    rsp.wake_valid <= 1'b1; rsp.wake_pid <= rown[s]; blk[s] <= 1'b0;
                  end else if (!seal[s]) begin
                    blk[s] <= 1'b0;
                  end
                end
                rsp.status <= ST_OK;
              end else if (rd_v[s] && rown[s] == req.process_id) begin
                rd_v[s] <= 1'b0;
                if (blk[s] && wr_v[s]) begin
                  rsp.wake_valid <= 1'b1; rsp.wake_pid <= wown[s];
                end
                blk[s] <= 1'b0; used[s] <= 1'b0; wr_v[s] <= 1'b0;
                if (used_count != '0) used_count <= used_count - 1'b1;
                rsp.status <= ST_OK;
              end
            end
          end
          OP_WRITE: begin
            if (wr_ok) begin
              if (seal[s]) begin
                rsp.status <= ST_SEAL;
              end else if (fill[s] >= FW'(BUFFER_DEPTH)) begin
                blk[s] <= 1'b1; rsp.status <= ST_BLOCK;
              end else begin
                if (req.data_byte == end_marker) seal[s] <= 1'b1;
                else fill[s] <= fill[s] + 1'b1;
                if (blk[s]) begin
                  if (rd_v[s]) begin
                    rsp.wake_valid <= 1'b1; rsp.wake_pid <= rown[s];
                  end
                  blk[s] <= 1'b0;
                end
                rsp.status <= ST_OK;
              end
            end
          end
          OP_READ: begin
            if (idx_ok && used[s] && rd_v[s] && rown[s] == req.process_id) begin
              if (fill[s] == '0 && !seal[s]) begin
                blk[s] <= 1'b1; rsp.status <= ST_BLOCK;
              end else begin
                if (fill[s] != '0) begin
                  rsp.read_byte <= st_rdata;
                  head[s] <= (head[s] == DW'(BUFFER_DEPTH - 1)) ? '0 : head[s] + 1'b1;
                  fill[s] <= fill[s] - 1'b1;
                end else begin
                  rsp.read_byte <= end_marker; rsp.is_end <= 1'b1;
                end
                if (blk[s]) begin
                  if (wr_v[s]) begin
                    rsp.wake_valid <= 1'b1; rsp.wake_pid <= wown[s];
                  end
                  blk[s] <= 1'b0;
                end
                rsp.status <= ST_OK;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule
